// ===== hdl/pfm_pkg.sv =====
// Shared types, codes and helper functions for the pixel FIFO mixer.
`timescale 1ns / 1ps

package pfm_pkg;

   // Pixels carried by one row transaction and bits per pixel color.
   localparam int ROW_PIXELS = 8;
   localparam int COLOR_W    = 2;
   localparam int ROW_W      = ROW_PIXELS * COLOR_W;

   // Sprite flag bits kept in every slot.
   localparam int FLAG_PRESENT = 1;
   localparam int FLAG_BEHIND  = 0;

   // Operation codes of the request channel.
   typedef enum logic [1:0] {
      ACT_PUSH_BG     = 2'd0,
      ACT_PUSH_SPRITE = 2'd1,
      ACT_POP         = 2'd2,
      ACT_CLEAR       = 2'd3
   } action_type;

   // Configuration register indexes.
   typedef enum logic [1:0] {
      CSR_BG_PAL   = 2'd0,
      CSR_SPR_PAL0 = 2'd1,
      CSR_SPR_PAL1 = 2'd2,
      CSR_UNUSED   = 2'd3
   } csr_index_type;

   // Contents of one FIFO slot.
   typedef struct packed {
      logic [COLOR_W-1:0] bg_color;
      logic [COLOR_W-1:0] spr_color;
      logic               spr_pal;
      logic [1:0]         spr_flags;
   } slot_type;

   // Per-transaction control broadcast to every slot.
   typedef struct packed {
      logic             do_pop;
      logic             do_clear;
      logic             do_bg;
      logic             do_spr;
      logic [ROW_W-1:0] row;
      logic [ROW_W-1:0] spr_row;
      logic [2:0]       spr_skip;
      logic [3:0]       spr_count;
      logic [1:0]       spr_flags;
      logic             spr_pal;
   } slot_ctrl_type;

   // Color of pixel idx in a row; pixel 0 sits in the top bits.
   function automatic logic [COLOR_W-1:0] pixel_at(input logic [ROW_W-1:0] row,
                                                   input logic [2:0] idx);
      logic [2:0] pos;
      pos = 3'(ROW_PIXELS - 1) - idx;
      return row[pos*COLOR_W +: COLOR_W];
   endfunction

   // Shade of a color looked up in a four-entry palette.
   function automatic logic [1:0] shade_of(input logic [7:0] pal,
                                           input logic [COLOR_W-1:0] color);
      return pal[color*2 +: 2];
   endfunction

endpackage

// ===== hdl/pfm_slot.sv =====
// One FIFO slot cell: holds a pixel and takes its neighbor's pixel on a pop.
`timescale 1ns / 1ps

module pfm_slot #(
   parameter int SLOT_INDEX = 0,
   parameter int FILL_W     = 5
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  step,
   input  pfm_pkg::slot_ctrl_type ctrl,
   input  logic [FILL_W-1:0]     fill_count,
   input  pfm_pkg::slot_type     next_slot,
   output pfm_pkg::slot_type     slot
);

   localparam logic [FILL_W:0] IDX = (FILL_W+1)'(SLOT_INDEX);

   pfm_pkg::slot_type slot_ff;
   pfm_pkg::slot_type slot_in;
   logic [FILL_W:0]   bg_off;
   logic [2:0]        spr_src;
   logic              spr_hit;
   logic              spr_free;

   // Position of this slot relative to the background write point.
   assign bg_off  = IDX - {1'b0, fill_count};
   assign spr_src = ctrl.spr_skip + 3'(SLOT_INDEX);
   assign spr_hit = (SLOT_INDEX < pfm_pkg::ROW_PIXELS) &&
                    ({1'b0, IDX} < (FILL_W+2)'(ctrl.spr_count));
   assign spr_free = !slot_ff.spr_flags[pfm_pkg::FLAG_PRESENT] ||
                     (slot_ff.spr_color == '0);

   // Next slot contents for the operation in flight.
   always_comb begin
      slot_in = slot_ff;
      if (ctrl.do_clear) begin
         slot_in = '0;
      end else if (ctrl.do_pop) begin
         slot_in = next_slot;
      end else if (ctrl.do_bg) begin
         if (IDX >= {1'b0, fill_count}) begin
            if (bg_off < (FILL_W+1)'(pfm_pkg::ROW_PIXELS)) begin
               slot_in.bg_color = pfm_pkg::pixel_at(ctrl.row, bg_off[2:0]);
            end else begin
               slot_in.bg_color = '0;
            end
         end
      end else if (ctrl.do_spr) begin
         if (spr_hit && spr_free) begin
            slot_in.spr_color = pfm_pkg::pixel_at(ctrl.spr_row, spr_src);
            slot_in.spr_flags = ctrl.spr_flags;
            slot_in.spr_pal   = ctrl.spr_pal;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         slot_ff <= '0;
      end else if (step) begin
         slot_ff <= slot_in;
      end
   end

   assign slot = slot_ff;

endmodule

// ===== hdl/pfm_out.sv =====
// Pixel mixer and two-entry output buffer of the response channel.
`timescale 1ns / 1ps

module pfm_out (
   input  logic              clock,
   input  logic              reset,
   input  logic              pop,
   input  pfm_pkg::slot_type front,
   input  logic [7:0]        bg_pal,
   input  logic [7:0]        spr_pal0,
   input  logic [7:0]        spr_pal1,
   output logic              full,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output logic [1:0]        rsp_shade
);

   logic       main_valid_ff, main_valid_in;
   logic [1:0] main_shade_ff, main_shade_in;
   logic       skid_valid_ff, skid_valid_in;
   logic [1:0] skid_shade_ff, skid_shade_in;
   logic [1:0] mix_shade;
   logic       spr_wins;
   logic       take;

   // Sprite beats background unless it is absent, transparent or behind a nonzero background color.
   assign spr_wins = front.spr_flags[pfm_pkg::FLAG_PRESENT] && (front.spr_color != '0) &&
                     !(front.spr_flags[pfm_pkg::FLAG_BEHIND] && (front.bg_color != '0));

   always_comb begin
      if (spr_wins) begin
         mix_shade = pfm_pkg::shade_of(front.spr_pal ? spr_pal1 : spr_pal0, front.spr_color);
      end else begin
         mix_shade = pfm_pkg::shade_of(bg_pal, front.bg_color);
      end
   end

   assign take = main_valid_ff && !rsp_stall;

   // The skid entry catches a pop result while the output register is held.
   always_comb begin
      main_valid_in = main_valid_ff;
      main_shade_in = main_shade_ff;
      skid_valid_in = skid_valid_ff;
      skid_shade_in = skid_shade_ff;
      if (skid_valid_ff) begin
         if (take) begin
            main_shade_in = skid_shade_ff;
            skid_valid_in = 1'b0;
         end
      end else if (pop) begin
         if (!main_valid_ff || take) begin
            main_valid_in = 1'b1;
            main_shade_in = mix_shade;
         end else begin
            skid_valid_in = 1'b1;
            skid_shade_in = mix_shade;
         end
      end else if (take) begin
         main_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         main_valid_ff <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         main_valid_ff <= main_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
      main_shade_ff <= main_shade_in;
      skid_shade_ff <= skid_shade_in;
   end

   assign full      = skid_valid_ff;
   assign rsp_valid = main_valid_ff;
   assign rsp_shade = main_shade_ff;

endmodule

// ===== hdl/pixel_fifo_mixer.sv =====
// Top level of the pixel FIFO mixer: slot chain, fill counter and palettes.
`timescale 1ns / 1ps
//
// Line pixel FIFO that mixes background and sprite pixels for a display.
// Request channel (req_*): each transaction carries one action: push a
// background row, merge a sprite row into the front slots, pop one pixel,
// or clear. Only a pop produces a response transaction (rsp_shade).
// Configuration (csr_*): three palette registers written with csr_wr_en;
// write them only while no transaction is in flight.
// Throughput: one request transaction every cycle while req_stall is low. The
// slots form a chain of cells that all update together, so each accepted action
// is held in the slot registers in the cycle after it is accepted.
// Response: a pop's shade is registered in the output buffer and appears on
// rsp_shade with rsp_valid high.
// Reset (synchronous): all slots empty, fill count zero, palettes zero.
// Back pressure: a two-entry output buffer absorbs one pop while rsp_stall
// is held; req_stall rises once both entries are full and falls when the
// receiver takes a result.
//
module pixel_fifo_mixer #(
   parameter int QUEUE_SLOTS = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [1:0]  req_action,
   input  logic [15:0] req_pixel_row,
   input  logic        req_sprite_behind_bg,
   input  logic        req_sprite_mirror,
   input  logic [7:0]  req_sprite_xpos,
   input  logic        req_sprite_palette_sel,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [1:0]  rsp_shade,
   input  logic        csr_wr_en,
   input  logic [1:0]  csr_index,
   input  logic [7:0]  csr_wdata
);

   localparam int FILL_W = $clog2(QUEUE_SLOTS + 1);

   pfm_pkg::action_type    action;
   pfm_pkg::slot_ctrl_type ctrl;
   pfm_pkg::slot_type      slots [QUEUE_SLOTS+1];
   logic                   req_accept;
   logic                   out_full;
   logic [FILL_W-1:0]      fill_count_ff, fill_count_in;
   logic [7:0]             bg_pal_ff, spr_pal0_ff, spr_pal1_ff;

   assign action     = pfm_pkg::action_type'(req_action);
   assign req_stall  = out_full;
   assign req_accept = req_valid && !req_stall;

   // Decode the transaction into control shared by all slot cells.
   always_comb begin
      ctrl           = '0;
      ctrl.row       = req_pixel_row;
      ctrl.spr_pal   = req_sprite_palette_sel;
      ctrl.spr_flags = {1'b1, req_sprite_behind_bg};
      for (int k = 0; k < pfm_pkg::ROW_PIXELS; k++) begin
         ctrl.spr_row[k*pfm_pkg::COLOR_W +: pfm_pkg::COLOR_W] = req_sprite_mirror ?
            req_pixel_row[(pfm_pkg::ROW_PIXELS-1-k)*pfm_pkg::COLOR_W +: pfm_pkg::COLOR_W] :
            req_pixel_row[k*pfm_pkg::COLOR_W +: pfm_pkg::COLOR_W];
      end
      // A sprite partly off the left edge keeps only its rightmost pixels.
      if (req_sprite_xpos inside {[8'd1:8'd7]}) begin
         ctrl.spr_count = req_sprite_xpos[3:0];
         ctrl.spr_skip  = 3'(4'(pfm_pkg::ROW_PIXELS) - req_sprite_xpos[3:0]);
      end else begin
         ctrl.spr_count = 4'(pfm_pkg::ROW_PIXELS);
         ctrl.spr_skip  = '0;
      end
      case (action)
         pfm_pkg::ACT_PUSH_BG: begin
            ctrl.do_bg = (fill_count_ff <= FILL_W'(pfm_pkg::ROW_PIXELS));
         end
         pfm_pkg::ACT_PUSH_SPRITE: begin
            ctrl.do_spr = 1'b1;
         end
         pfm_pkg::ACT_POP: begin
            ctrl.do_pop = 1'b1;
         end
         pfm_pkg::ACT_CLEAR: begin
            ctrl.do_clear = 1'b1;
         end
         default: begin
            ctrl.do_clear = 1'b0;
         end
      endcase
   end

   // Chain of slot cells; empty slots enter at the back on a pop.
   assign slots[QUEUE_SLOTS] = '0;

   for (genvar s = 0; s < QUEUE_SLOTS; s++) begin : g_slot
      pfm_slot #(
         .SLOT_INDEX (s),
         .FILL_W     (FILL_W)
      ) u_slot (
         .clock      (clock),
         .reset      (reset),
         .step       (req_accept),
         .ctrl       (ctrl),
         .fill_count (fill_count_ff),
         .next_slot  (slots[s+1]),
         .slot       (slots[s])
      );
   end

   // Count of queued background pixels.
   always_comb begin
      fill_count_in = fill_count_ff;
      if (req_accept) begin
         if (ctrl.do_clear) begin
            fill_count_in = '0;
         end else if (ctrl.do_pop) begin
            if (fill_count_ff != '0) begin
               fill_count_in = fill_count_ff - 1'b1;
            end
         end else if (ctrl.do_bg) begin
            fill_count_in = fill_count_ff + FILL_W'(pfm_pkg::ROW_PIXELS);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_count_ff <= '0;
      end else begin
         fill_count_ff <= fill_count_in;
      end
   end

   // Palette registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         bg_pal_ff   <= '0;
         spr_pal0_ff <= '0;
         spr_pal1_ff <= '0;
      end else if (csr_wr_en) begin
         case (pfm_pkg::csr_index_type'(csr_index))
            pfm_pkg::CSR_BG_PAL:   bg_pal_ff   <= csr_wdata;
            pfm_pkg::CSR_SPR_PAL0: spr_pal0_ff <= csr_wdata;
            pfm_pkg::CSR_SPR_PAL1: spr_pal1_ff <= csr_wdata;
            default: begin
               bg_pal_ff <= bg_pal_ff;
            end
         endcase
      end
   end

   // Mixing of the front slot and the response buffer.
   pfm_out u_out (
      .clock     (clock),
      .reset     (reset),
      .pop       (req_accept && ctrl.do_pop),
      .front     (slots[0]),
      .bg_pal    (bg_pal_ff),
      .spr_pal0  (spr_pal0_ff),
      .spr_pal1  (spr_pal1_ff),
      .full      (out_full),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_shade (rsp_shade)
   );

   // The fill count never runs past the number of slots.
   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      fill_count_ff <= FILL_W'(QUEUE_SLOTS))
      else $error("fill count beyond slot count");

   // An accepted pop always shows a result in the next cycle.
   a_pop_result: assert property (@(posedge clock) disable iff (reset)
      (req_accept && action == pfm_pkg::ACT_POP) |=> rsp_valid)
      else $error("pop produced no response");

   // A clear leaves the FIFO empty.
   a_clear_empty: assert property (@(posedge clock) disable iff (reset)
      (req_accept && action == pfm_pkg::ACT_CLEAR) |=>
      (fill_count_ff == '0 && slots[0] == '0))
      else $error("clear left data behind");

   // Requests are held off only while a response is waiting.
   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> rsp_valid)
      else $error("request stalled with no pending response");

endmodule
